/* hw/rtl/fmpq_pkg.sv */
package fmpq_pkg;

  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned AMOUNT_W   = 24;
  localparam int unsigned CUSTOMER_W = 32;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [ACTION_W-1:0] ACT_ARRIVE       = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SERVE_OLDEST = 2'd1;

  localparam logic [STATUS_W-1:0] STATUS_ARRIVED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SERVED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SKIP,
    S_CHECK,
    S_EXEC,
    S_SCAN,
    S_CLEAR,
    S_RESULT
  } state_e;

endpackage

/* hw/rtl/fmpq_in_if.sv */
interface fmpq_in_if import fmpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, output action, output amount, input ready);
  modport sink (input valid, input action, input amount, output ready);
endinterface

/* hw/rtl/fmpq_out_if.sv */
interface fmpq_out_if import fmpq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CUSTOMER_W-1:0] customer;
  logic [STATUS_W-1:0]   status;

  modport source (output valid, output customer, output status, input ready);
  modport sink (input valid, input customer, input status, output ready);
endinterface

/* hw/rtl/fifo_and_max_priority_queue.sv */
// Channel | Dir | Payload            | Transaction
// in_i    | in  | action, amount     | valid && ready
// out_o   | out | customer, status   | valid && ready
//
// One transaction at a time; in_i.ready is high only while no item is in work.
// Arrival and serve-oldest step through skip and exec, with a check and a skip step
// per served entry the head passes over (one read of the slot memory each).
// Serve-largest adds a scan step per number in the span, one memory read each.
// Reset is asynchronous and needs no clearing pass: only slots inside the live
// span are read, and each of those was written at its arrival.
// A finished result waits in the output register; the next item is accepted
// meanwhile and its result is held until the register is taken.
module fifo_and_max_priority_queue import fmpq_pkg::*; #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  fmpq_in_if.sink            in_i,
  fmpq_out_if.source         out_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned DW = AMOUNT_W + 1;

  typedef logic [AW-1:0]         slot_t;
  typedef logic [CUSTOMER_W-1:0] num_t;

  function automatic slot_t slot_inc(slot_t s);
    slot_t r;
    if (s == slot_t'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = s + slot_t'(1);
    end
    return r;
  endfunction

  logic [DW-1:0] mem_q [CAPACITY];
  logic [DW-1:0] rd_q;
  logic          mem_we;
  slot_t         waddr;
  slot_t         raddr;
  logic [DW-1:0] wdata;

  state_e state_q, state_d;
  num_t   next_num_q, next_num_d;
  num_t   head_num_q, head_num_d;
  slot_t  next_slot_q, next_slot_d;
  slot_t  head_slot_q, head_slot_d;
  logic   pend_vld_q, pend_vld_d;
  logic   out_valid_q, out_valid_d;

  logic [ACTION_W-1:0]   action_q, action_d;
  logic [AMOUNT_W-1:0]   amount_q, amount_d;
  num_t                  scan_num_q, scan_num_d;
  slot_t                 scan_slot_q, scan_slot_d;
  num_t                  pend_num_q, pend_num_d;
  slot_t                 pend_slot_q, pend_slot_d;
  num_t                  best_num_q, best_num_d;
  slot_t                 best_slot_q, best_slot_d;
  logic [AMOUNT_W-1:0]   best_amt_q, best_amt_d;
  num_t                  res_cust_q, res_cust_d;
  logic [STATUS_W-1:0]   res_stat_q, res_stat_d;
  num_t                  out_cust_q, out_cust_d;
  logic [STATUS_W-1:0]   out_stat_q, out_stat_d;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  always_comb begin
    state_d     = state_q;
    next_num_d  = next_num_q;
    head_num_d  = head_num_q;
    next_slot_d = next_slot_q;
    head_slot_d = head_slot_q;
    pend_vld_d  = pend_vld_q;
    out_valid_d = out_valid_q;
    action_d    = action_q;
    amount_d    = amount_q;
    scan_num_d  = scan_num_q;
    scan_slot_d = scan_slot_q;
    pend_num_d  = pend_num_q;
    pend_slot_d = pend_slot_q;
    best_num_d  = best_num_q;
    best_slot_d = best_slot_q;
    best_amt_d  = best_amt_q;
    res_cust_d  = res_cust_q;
    res_stat_d  = res_stat_q;
    out_cust_d  = out_cust_q;
    out_stat_d  = out_stat_q;
    mem_we      = 1'b0;
    waddr       = head_slot_q;
    wdata       = rd_q;
    raddr       = head_slot_q;
    in_i.ready  = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          action_d = in_i.action;
          amount_d = in_i.amount;
          state_d  = S_SKIP;
        end
      end
      S_SKIP: begin
        if (head_num_q == next_num_q) begin
          state_d = S_EXEC;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!rd_q[DW-1]) begin
          head_num_d  = head_num_q + num_t'(1);
          head_slot_d = slot_inc(head_slot_q);
          state_d     = S_SKIP;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESULT;
        if (action_q == ACT_ARRIVE) begin
          if ((next_num_q - head_num_q) >= num_t'(CAPACITY)) begin
            res_cust_d = '0;
            res_stat_d = STATUS_FULL;
          end else begin
            mem_we      = 1'b1;
            waddr       = next_slot_q;
            wdata       = {1'b1, amount_q};
            res_cust_d  = next_num_q;
            res_stat_d  = STATUS_ARRIVED;
            next_num_d  = next_num_q + num_t'(1);
            next_slot_d = slot_inc(next_slot_q);
          end
        end else if (head_num_q == next_num_q) begin
          res_cust_d = '0;
          res_stat_d = STATUS_EMPTY;
        end else if (action_q == ACT_SERVE_OLDEST) begin
          mem_we      = 1'b1;
          waddr       = head_slot_q;
          wdata       = {1'b0, rd_q[AMOUNT_W-1:0]};
          res_cust_d  = head_num_q;
          res_stat_d  = STATUS_SERVED;
          head_num_d  = head_num_q + num_t'(1);
          head_slot_d = slot_inc(head_slot_q);
        end else begin
          best_num_d  = head_num_q;
          best_slot_d = head_slot_q;
          best_amt_d  = rd_q[AMOUNT_W-1:0];
          scan_num_d  = head_num_q + num_t'(1);
          scan_slot_d = slot_inc(head_slot_q);
          pend_vld_d  = 1'b0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        raddr = scan_slot_q;
        if (pend_vld_q && rd_q[DW-1] && (rd_q[AMOUNT_W-1:0] > best_amt_q)) begin
          best_num_d  = pend_num_q;
          best_slot_d = pend_slot_q;
          best_amt_d  = rd_q[AMOUNT_W-1:0];
        end
        if (scan_num_q != next_num_q) begin
          pend_vld_d  = 1'b1;
          pend_num_d  = scan_num_q;
          pend_slot_d = scan_slot_q;
          scan_num_d  = scan_num_q + num_t'(1);
          scan_slot_d = slot_inc(scan_slot_q);
        end else begin
          pend_vld_d = 1'b0;
          if (!pend_vld_q) begin
            state_d = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        mem_we     = 1'b1;
        waddr      = best_slot_q;
        wdata      = {1'b0, best_amt_q};
        res_cust_d = best_num_q;
        res_stat_d = STATUS_SERVED;
        state_d    = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_cust_d  = res_cust_q;
          out_stat_d  = res_stat_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_num_q  <= num_t'(1);
      head_num_q  <= num_t'(1);
      next_slot_q <= slot_t'(1);
      head_slot_q <= slot_t'(1);
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_num_q  <= next_num_d;
      head_num_q  <= head_num_d;
      next_slot_q <= next_slot_d;
      head_slot_q <= head_slot_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q    <= action_d;
    amount_q    <= amount_d;
    scan_num_q  <= scan_num_d;
    scan_slot_q <= scan_slot_d;
    pend_num_q  <= pend_num_d;
    pend_slot_q <= pend_slot_d;
    best_num_q  <= best_num_d;
    best_slot_q <= best_slot_d;
    best_amt_q  <= best_amt_d;
    res_cust_q  <= res_cust_d;
    res_stat_q  <= res_stat_d;
    out_cust_q  <= out_cust_d;
    out_stat_q  <= out_stat_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.customer = out_cust_q;
  assign out_o.status   = out_stat_q;

endmodule
